FILE: src/fdssd_pkg.sv
// shared types, constants and glyph lookup for the seven-segment driver
`timescale 1ns / 1ps

package fdssd_pkg;

   localparam int DigitCount = 4;
   localparam int NumberWidth = 16;
   localparam int RemWidth = 14;
   localparam int PosWidth = 2;

   localparam logic [RemWidth-1:0] MaxShown = 14'd9999;
   localparam logic [7:0] PatternBlank = 8'hFF;
   localparam logic [PosWidth-1:0] LastPos = 2'd3;

   localparam logic CmdSet = 1'b0;
   localparam logic CmdRefresh = 1'b1;

   // digit write from the conversion unit into the pattern store
   typedef struct packed {
      logic                en;
      logic [PosWidth-1:0] pos;
      logic [7:0]          pattern;
      logic                done;
   } digit_wr_type;

   // active-low segments dp g f e d c b a
   function automatic logic [7:0] glyph(input logic [3:0] digit);
      logic [7:0] seg;
      unique case (digit)
         4'd0: seg = 8'hC0;
         4'd1: seg = 8'hF9;
         4'd2: seg = 8'hA4;
         4'd3: seg = 8'hB0;
         4'd4: seg = 8'h99;
         4'd5: seg = 8'h92;
         4'd6: seg = 8'h82;
         4'd7: seg = 8'hF8;
         4'd8: seg = 8'h80;
         4'd9: seg = 8'h90;
         default: seg = PatternBlank;
      endcase
      return seg;
   endfunction

   // decimal weight of a digit position, leftmost first
   function automatic logic [RemWidth-1:0] place_value(input logic [PosWidth-1:0] pos);
      logic [RemWidth-1:0] val;
      unique case (pos)
         2'd0: val = 14'd1000;
         2'd1: val = 14'd100;
         2'd2: val = 14'd10;
         default: val = 14'd1;
      endcase
      return val;
   endfunction

endpackage

FILE: src/fdssd_bcd_unit.sv
// decimal digit extraction by repeated compare and subtract
`timescale 1ns / 1ps

module fdssd_bcd_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [fdssd_pkg::NumberWidth-1:0]    number,
   input  logic                                 show_zeros,
   output fdssd_pkg::digit_wr_type              wr
);

   logic                                busy_ff, busy_in;
   logic [fdssd_pkg::RemWidth-1:0]      rem_ff, rem_in;
   logic [fdssd_pkg::PosWidth-1:0]      pos_ff, pos_in;
   logic [3:0]                          digit_ff, digit_in;
   logic                                showing_ff, showing_in;

   logic [fdssd_pkg::RemWidth-1:0]      place;
   logic                                fits;
   logic [3:0]                          cur_digit;
   logic                                blank;

   assign place = fdssd_pkg::place_value(pos_ff);
   assign fits = (rem_ff >= place) && (pos_ff != fdssd_pkg::LastPos);
   // rightmost digit is simply what remains
   assign cur_digit = (pos_ff == fdssd_pkg::LastPos) ? rem_ff[3:0] : digit_ff;
   assign blank = !showing_ff && (cur_digit == 4'd0) && (pos_ff != fdssd_pkg::LastPos);

   always_comb begin
      busy_in = busy_ff;
      rem_in = rem_ff;
      pos_in = pos_ff;
      digit_in = digit_ff;
      showing_in = showing_ff;
      wr.en = 1'b0;
      wr.pos = pos_ff;
      wr.pattern = blank ? fdssd_pkg::PatternBlank : fdssd_pkg::glyph(cur_digit);
      wr.done = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         rem_in = (number > {2'b00, fdssd_pkg::MaxShown}) ?
                  fdssd_pkg::MaxShown : number[fdssd_pkg::RemWidth-1:0];
         pos_in = '0;
         digit_in = '0;
         showing_in = show_zeros;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - place;
            digit_in = digit_ff + 4'd1;
         end else begin
            wr.en = 1'b1;
            if (!blank) begin
               showing_in = 1'b1;
            end
            digit_in = '0;
            pos_in = pos_ff + 2'd1;
            if (pos_ff == fdssd_pkg::LastPos) begin
               busy_in = 1'b0;
               wr.done = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      rem_ff <= rem_in;
      pos_ff <= pos_in;
      digit_ff <= digit_in;
      showing_ff <= showing_in;
   end

endmodule

FILE: src/four_digit_seven_segment_driver.sv
// four-digit seven-segment display driver, top level
//
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------------------
//  req      | req_tvalid / req_tready | tuser: cmd, tdata: number[15:0]
//  rsp      | rsp_tvalid / rsp_tready | tdata: segment, select, index; tlast
//  csr      | csr_we                  | csr_wdata: show_leading_zeros
//
// a set transaction runs one compare-subtract unit over the thousands, hundreds
// and tens places, one subtraction or digit write per step
// a refresh transaction sends four frames, one per cycle out of the output
// register, stalling while rsp_tready is low
// req_tready is high only while the sequencer is idle
// synchronous reset blanks all four digits and clears show_leading_zeros
`timescale 1ns / 1ps

module four_digit_seven_segment_driver (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] number
   input  logic        req_tuser,   // [0] cmd: 0 set, 1 refresh
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] segment_byte, [11:8] select_byte,
                                    // [13:12] digit_index, [15:14] zero
   output logic        rsp_tlast,   // last_of_scan
   input  logic        csr_we,
   input  logic        csr_wdata    // show_leading_zeros
);

   typedef enum logic [2:0] {
      ST_IDLE    = 3'b001,
      ST_CONVERT = 3'b010,
      ST_EMIT    = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic show_zeros_ff;

   // stored segment patterns, leftmost digit at index 0
   logic [7:0] patterns_ff [fdssd_pkg::DigitCount];

   logic [fdssd_pkg::PosWidth-1:0] emit_pos_ff, emit_pos_in;

   // output register
   logic                           out_valid_ff, out_valid_in;
   logic [7:0]                     out_seg_ff, out_seg_in;
   logic [3:0]                     out_sel_ff, out_sel_in;
   logic [fdssd_pkg::PosWidth-1:0] out_idx_ff, out_idx_in;
   logic                           out_last_ff, out_last_in;

   logic                    req_fire;
   logic                    conv_start;
   fdssd_pkg::digit_wr_type conv_wr;
   logic                    slot_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire = req_tvalid && req_tready;
   assign conv_start = req_fire && (req_tuser == fdssd_pkg::CmdSet);
   assign slot_free = !out_valid_ff || rsp_tready;

   fdssd_bcd_unit u_bcd (
      .clock      (clock),
      .reset      (reset),
      .start      (conv_start),
      .number     (req_tdata),
      .show_zeros (show_zeros_ff),
      .wr         (conv_wr)
   );

   // sequencer and frame emission
   always_comb begin
      state_in = state_ff;
      emit_pos_in = emit_pos_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_seg_in = out_seg_ff;
      out_sel_in = out_sel_ff;
      out_idx_in = out_idx_ff;
      out_last_in = out_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser == fdssd_pkg::CmdSet) begin
                  state_in = ST_CONVERT;
               end else begin
                  state_in = ST_EMIT;
                  emit_pos_in = '0;
               end
            end
         end
         ST_CONVERT: begin
            if (conv_wr.done) begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            // next frame goes out once the output register has room
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_seg_in = patterns_ff[emit_pos_ff];
               out_sel_in = 4'b1000 >> emit_pos_ff;
               out_idx_in = emit_pos_ff;
               out_last_in = (emit_pos_ff == fdssd_pkg::LastPos);
               emit_pos_in = emit_pos_ff + 2'd1;
               if (emit_pos_ff == fdssd_pkg::LastPos) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_valid_ff <= 1'b0;
         show_zeros_ff <= 1'b0;
         for (int i = 0; i < fdssd_pkg::DigitCount; i++) begin
            patterns_ff[i] <= fdssd_pkg::PatternBlank;
         end
      end else begin
         state_ff <= state_in;
         out_valid_ff <= out_valid_in;
         if (csr_we) begin
            show_zeros_ff <= csr_wdata;
         end
         if (conv_wr.en) begin
            patterns_ff[conv_wr.pos] <= conv_wr.pattern;
         end
      end
      emit_pos_ff <= emit_pos_in;
      out_seg_ff <= out_seg_in;
      out_sel_ff <= out_sel_in;
      out_idx_ff <= out_idx_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = {2'b00, out_idx_ff, out_sel_ff, out_seg_ff};
   assign rsp_tlast = out_last_ff;

endmodule

FILE: src/fdssd_checker.sv
// port-level checks for the seven-segment driver, bound to the top level
`timescale 1ns / 1ps

module fdssd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast
);

   // a stalled frame holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled frame changed");

   // select byte matches the frame position
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         (rsp_tdata[13:12] == 2'd0 && rsp_tdata[11:8] == 4'b1000) ||
         (rsp_tdata[13:12] == 2'd1 && rsp_tdata[11:8] == 4'b0100) ||
         (rsp_tdata[13:12] == 2'd2 && rsp_tdata[11:8] == 4'b0010) ||
         (rsp_tdata[13:12] == 2'd3 && rsp_tdata[11:8] == 4'b0001))
      else $error("select byte does not match digit index");

   // last mark only on the rightmost frame
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tdata[13:12] == 2'd3)))
      else $error("last mark on wrong frame");

   // a set transaction leaves the block busy in the cycle after it is accepted
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tuser |=> !req_tready)
      else $error("ready right after a set transaction");

   // reset leaves the block idle with no frame pending
   assert property (@(posedge clock)
      reset |=> req_tready && !rsp_tvalid)
      else $error("not idle after reset");

endmodule

bind four_digit_seven_segment_driver fdssd_checker u_fdssd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
